[hdl/assert_macros.svh]
// Assertion helpers for the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define SWMM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("concurrent check failed");

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define SWMM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("concurrent check failed");

`endif

[hdl/swmm_pkg.sv]
package swmm_pkg;

    // Field widths fixed by the interface.
    localparam int OP_W      = 2;
    localparam int VAL_W     = 10;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;
    localparam int RC_W      = 9;
    localparam int CNT_OUT_W = 9;
    localparam int TOT_W     = 32;

    // Stream bus widths: tdata in whole bytes, tuser as wide as the opcode.
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = OP_W;
    localparam int M_TDATA_W = 48;

    // Bit positions of the result fields inside the master tdata.
    localparam int OUT_FULL_LSB  = 0;
    localparam int OUT_MATCH_LSB = 1;
    localparam int OUT_CNT_LSB   = 2;
    localparam int OUT_TOT_LSB   = OUT_CNT_LSB + CNT_OUT_W;

    // Default sizes of the symbol alphabet and of the window.
    localparam int ALPHABET_SIZE_DEF = 1024;
    localparam int WINDOW_MAX_DEF    = 256;

    // Reference counts saturate here.
    localparam logic [RC_W-1:0] REF_MAX = 9'd511;

    // Request opcodes.
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
    localparam logic [OP_W-1:0] OP_PUSH  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_THRESHOLD = 2'd1;

    // Configuration as seen by the core.
    typedef struct packed {
        logic [CFG_W-1:0] window_length;
        logic [CFG_W-1:0] threshold;
        logic             restart;
    } t_cfg;

endpackage

[hdl/swmm_ram.sv]
// Simple dual-port style RAM: one write port, two registered read ports.
module swmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read ports return the contents before a same-cycle write; data holds while idle.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= mem[i_raddr_a];
            o_rdata_b <= mem[i_raddr_b];
        end
    end

endmodule

[hdl/swmm_fold.sv]
// Input register stage. It also folds the symbol value into the alphabet,
// using a reciprocal multiply before the register and the remainder after it.
module swmm_fold #(
    parameter int ALPHABET_SIZE = swmm_pkg::ALPHABET_SIZE_DEF,
    localparam int AW = $clog2(ALPHABET_SIZE)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [swmm_pkg::OP_W-1:0] i_op,
    input  logic [swmm_pkg::VAL_W-1:0] i_value,
    input  logic                      i_block,
    output logic                      o_valid,
    input  logic                      i_take,
    output logic [swmm_pkg::OP_W-1:0] o_op,
    output logic [AW-1:0]             o_sym
);

    // Quotient by reciprocal: exact for every value of VAL_W bits.
    localparam int FOLD_K  = swmm_pkg::VAL_W + $clog2(ALPHABET_SIZE);
    localparam int PROD_W  = swmm_pkg::VAL_W + FOLD_K;
    localparam logic [63:0] FOLD_M =
        ((64'd1 << FOLD_K) + 64'(ALPHABET_SIZE) - 64'd1) / 64'(ALPHABET_SIZE);

    logic                       r_valid;
    logic [swmm_pkg::OP_W-1:0]  r_op;
    logic [swmm_pkg::VAL_W-1:0] r_value;
    logic [swmm_pkg::VAL_W-1:0] r_quot;
    logic [PROD_W-1:0]          prod;
    logic [31:0]                rem_full;

    assign o_ready = (!r_valid || i_take) && !i_block;
    assign prod    = PROD_W'(i_value) * PROD_W'(FOLD_M);

    // Valid flag of the stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Payload of the stage.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_op    <= i_op;
            r_value <= i_value;
            r_quot  <= prod[PROD_W-1:FOLD_K];
        end
    end

    // Remainder of the fold.
    assign rem_full = 32'(r_value) - 32'(r_quot) * 32'(ALPHABET_SIZE);
    assign o_sym    = rem_full[AW-1:0];
    assign o_valid  = r_valid;
    assign o_op     = r_op;

endmodule

[hdl/swmm_core.sv]
// Two-phase engine over the count tables, the window ring, the clearing pass
// and the result register.
module swmm_core #(
    parameter int ALPHABET_SIZE = swmm_pkg::ALPHABET_SIZE_DEF,
    parameter int WINDOW_MAX    = swmm_pkg::WINDOW_MAX_DEF,
    localparam int AW = $clog2(ALPHABET_SIZE)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  swmm_pkg::t_cfg                 i_cfg,
    input  logic                           i_valid,
    input  logic [swmm_pkg::OP_W-1:0]      i_op,
    input  logic [AW-1:0]                  i_sym,
    output logic                           o_take,
    output logic                           o_sweep,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [swmm_pkg::M_TDATA_W-1:0] o_m_tdata
);

    localparam int RW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int FW = ($clog2(WINDOW_MAX + 1) > swmm_pkg::CNT_OUT_W) ?
                        $clog2(WINDOW_MAX + 1) : swmm_pkg::CNT_OUT_W;
    localparam int RC_W  = swmm_pkg::RC_W;
    localparam int TOT_W = swmm_pkg::TOT_W;

    // Sequencing.
    logic                      r_ph0;
    logic                      r_ph1;
    logic                      fire1;
    logic                      take;
    logic [swmm_pkg::OP_W-1:0] r_op;
    logic [AW-1:0]             r_sym;
    logic                      r_evict;
    logic                      r_fwd_a;
    logic                      r_fwd_b;
    logic [FW-1:0]             r_fwd_data;

    // Window state.
    logic [FW-1:0]    r_fill;
    logic [RW-1:0]    r_oldest;
    logic [FW-1:0]    r_paired;
    logic [TOT_W-1:0] r_total;
    logic [AW-1:0]    r_old_val;
    logic [FW-1:0]    n_fill;
    logic [RW-1:0]    n_oldest;
    logic [FW-1:0]    n_paired;
    logic [TOT_W-1:0] n_total;

    // Deferred write of the entered symbol's window count.
    logic          r_pend_valid;
    logic [AW-1:0] r_pend_addr;
    logic [FW-1:0] r_pend_data;

    // Clearing pass.
    logic          r_sweep;
    logic          r_sweep_ref;
    logic [AW-1:0] r_sweep_addr;
    logic          n_sweep;
    logic          n_sweep_ref;
    logic [AW-1:0] n_sweep_addr;

    // Result register.
    logic                           r_out_valid;
    logic [swmm_pkg::M_TDATA_W-1:0] r_out_tdata;
    logic [swmm_pkg::M_TDATA_W-1:0] n_out_tdata;

    // Effective configuration.
    logic [FW-1:0] wl_ext;
    logic [FW-1:0] len_eff;
    logic [FW-1:0] thr_ext;
    logic          evict_now;
    logic [RW-1:0] oldest_inc;
    logic [FW:0]   pos_sum;
    logic [RW-1:0] pos;

    // Memory ports.
    logic [FW-1:0]   wc_rd_a;
    logic [FW-1:0]   wc_rd_b;
    logic [RC_W-1:0] rc_rd_a;
    logic [RC_W-1:0] rc_rd_b;
    logic [AW-1:0]   ring_rd;
    logic            wc_we;
    logic [AW-1:0]   wc_waddr;
    logic [FW-1:0]   wc_wdata;
    logic            rc_we;
    logic [AW-1:0]   rc_waddr;
    logic [RC_W-1:0] rc_wdata;

    // Phase-one arithmetic.
    logic [FW-1:0]    wc_o;
    logic [FW-1:0]    wc_s;
    logic [FW-1:0]    wc_o_dec;
    logic [FW-1:0]    wc_s_eff;
    logic [FW-1:0]    wc_s_new;
    logic [FW-1:0]    rc_o_ext;
    logic [FW-1:0]    rc_s_ext;
    logic [FW-1:0]    paired_evict;
    logic [FW-1:0]    paired_push;
    logic [FW-1:0]    paired_load;
    logic [FW-1:0]    fill_push;
    logic [TOT_W-1:0] total_push;
    logic             push_full;
    logic             push_hit;
    logic             load_ok;
    logic [RC_W-1:0]  rc_inc;

    // Window length clamped to one through WINDOW_MAX.
    assign wl_ext  = FW'(i_cfg.window_length);
    assign thr_ext = FW'(i_cfg.threshold);
    always_comb begin
        if (wl_ext == '0) begin
            len_eff = FW'(1);
        end else if (wl_ext > FW'(WINDOW_MAX)) begin
            len_eff = FW'(WINDOW_MAX);
        end else begin
            len_eff = wl_ext;
        end
    end

    // A request enters phase zero when the engine frees up, never next to a clear.
    assign fire1  = r_ph1 && (!r_out_valid || i_m_tready);
    assign take   = i_valid && !r_sweep && !r_ph0 &&
                    (!r_ph1 || (fire1 && (r_op != swmm_pkg::OP_CLEAR)));
    assign o_take = take;

    // Ring positions: the slot after the oldest and the slot the new value takes.
    assign evict_now  = (r_op == swmm_pkg::OP_PUSH) && (r_fill >= len_eff) &&
                        (r_fill != '0);
    assign oldest_inc = (r_oldest == RW'(WINDOW_MAX - 1)) ? '0 : r_oldest + 1'b1;
    assign pos_sum    = (FW + 1)'(r_oldest) + (FW + 1)'(r_fill);
    always_comb begin
        if (pos_sum >= (FW + 1)'(WINDOW_MAX)) begin
            pos = RW'(pos_sum - (FW + 1)'(WINDOW_MAX));
        end else begin
            pos = RW'(pos_sum);
        end
    end

    // Window value ring: written in phase zero, read ahead at the next oldest slot.
    swmm_ram #(
        .WIDTH (AW),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .i_clk     (i_clk),
        .i_we      (r_ph0 && (r_op == swmm_pkg::OP_PUSH)),
        .i_waddr   (pos),
        .i_wdata   (r_sym),
        .i_re      (r_ph0),
        .i_raddr_a (oldest_inc),
        .i_raddr_b (oldest_inc),
        .o_rdata_a (ring_rd),
        .o_rdata_b ()
    );

    // Window count table write port: clearing pass, evicted count, entered count.
    always_comb begin
        wc_we    = 1'b0;
        wc_waddr = r_pend_addr;
        wc_wdata = r_pend_data;
        if (r_sweep) begin
            wc_we    = 1'b1;
            wc_waddr = r_sweep_addr;
            wc_wdata = '0;
        end else if (fire1 && (r_op == swmm_pkg::OP_PUSH) && r_evict) begin
            wc_we    = 1'b1;
            wc_waddr = r_old_val;
            wc_wdata = wc_o_dec;
        end else if (r_pend_valid) begin
            wc_we = 1'b1;
        end
    end

    swmm_ram #(
        .WIDTH (FW),
        .DEPTH (ALPHABET_SIZE)
    ) u_wc (
        .i_clk     (i_clk),
        .i_we      (wc_we),
        .i_waddr   (wc_waddr),
        .i_wdata   (wc_wdata),
        .i_re      (r_ph0),
        .i_raddr_a (r_old_val),
        .i_raddr_b (r_sym),
        .o_rdata_a (wc_rd_a),
        .o_rdata_b (wc_rd_b)
    );

    // Reference count table write port: clearing pass or a reference load.
    always_comb begin
        rc_we    = 1'b0;
        rc_waddr = r_sym;
        rc_wdata = rc_inc;
        if (r_sweep) begin
            rc_we    = r_sweep_ref;
            rc_waddr = r_sweep_addr;
            rc_wdata = '0;
        end else if (fire1 && (r_op == swmm_pkg::OP_LOAD) && load_ok) begin
            rc_we = 1'b1;
        end
    end

    swmm_ram #(
        .WIDTH (RC_W),
        .DEPTH (ALPHABET_SIZE)
    ) u_rc (
        .i_clk     (i_clk),
        .i_we      (rc_we),
        .i_waddr   (rc_waddr),
        .i_wdata   (rc_wdata),
        .i_re      (r_ph0),
        .i_raddr_a (r_old_val),
        .i_raddr_b (r_sym),
        .o_rdata_a (rc_rd_a),
        .o_rdata_b (rc_rd_b)
    );

    // Phase one: counts with the deferred write forwarded, then the pairing update.
    assign wc_o     = r_fwd_a ? r_fwd_data : wc_rd_a;
    assign wc_s     = r_fwd_b ? r_fwd_data : wc_rd_b;
    assign rc_o_ext = FW'(rc_rd_a);
    assign rc_s_ext = FW'(rc_rd_b);
    assign wc_o_dec = (wc_o != '0) ? wc_o - 1'b1 : '0;

    always_comb begin
        paired_evict = r_paired;
        if (r_evict && (rc_o_ext > wc_o_dec) && (r_paired != '0)) begin
            paired_evict = r_paired - 1'b1;
        end
    end

    assign wc_s_eff    = (r_evict && (r_sym == r_old_val)) ? wc_o_dec : wc_s;
    assign wc_s_new    = wc_s_eff + 1'b1;
    assign paired_push = (rc_s_ext >= wc_s_new) ? paired_evict + 1'b1 : paired_evict;
    assign fill_push   = r_evict ? r_fill : r_fill + 1'b1;
    assign push_full   = (fill_push >= len_eff);
    assign push_hit    = push_full && (paired_push >= thr_ext);
    assign total_push  = (push_hit && (r_total != '1)) ? r_total + 1'b1 : r_total;

    // Reference load: saturating count, pairs up when the window already holds it.
    assign load_ok     = (rc_rd_b < swmm_pkg::REF_MAX);
    assign rc_inc      = rc_rd_b + 1'b1;
    assign paired_load = (load_ok && (FW'(rc_inc) <= wc_s)) ? r_paired + 1'b1 : r_paired;

    // Next state of the window counters, the clearing pass and the result.
    always_comb begin
        n_fill       = r_fill;
        n_oldest     = r_oldest;
        n_paired     = r_paired;
        n_total      = r_total;
        n_sweep      = r_sweep;
        n_sweep_ref  = r_sweep_ref;
        n_sweep_addr = r_sweep_addr;
        n_out_tdata  = '0;
        n_out_tdata[swmm_pkg::OUT_CNT_LSB +: swmm_pkg::CNT_OUT_W] =
            r_paired[swmm_pkg::CNT_OUT_W-1:0];
        n_out_tdata[swmm_pkg::OUT_TOT_LSB +: TOT_W] = r_total;

        if (r_sweep) begin
            n_sweep_addr = r_sweep_addr + 1'b1;
            if (r_sweep_addr == AW'(ALPHABET_SIZE - 1)) begin
                n_sweep = 1'b0;
            end
        end

        if (fire1) begin
            unique case (r_op)
                swmm_pkg::OP_CLEAR: begin
                    n_fill       = '0;
                    n_oldest     = '0;
                    n_paired     = '0;
                    n_total      = '0;
                    n_sweep      = 1'b1;
                    n_sweep_ref  = 1'b1;
                    n_sweep_addr = '0;
                    n_out_tdata  = '0;
                end
                swmm_pkg::OP_LOAD: begin
                    n_paired = paired_load;
                    n_out_tdata[swmm_pkg::OUT_CNT_LSB +: swmm_pkg::CNT_OUT_W] =
                        paired_load[swmm_pkg::CNT_OUT_W-1:0];
                end
                swmm_pkg::OP_PUSH: begin
                    n_fill   = fill_push;
                    n_oldest = r_evict ? oldest_inc : r_oldest;
                    n_paired = paired_push;
                    n_total  = total_push;
                    n_out_tdata[swmm_pkg::OUT_FULL_LSB]  = push_full;
                    n_out_tdata[swmm_pkg::OUT_MATCH_LSB] = push_hit;
                    n_out_tdata[swmm_pkg::OUT_CNT_LSB +: swmm_pkg::CNT_OUT_W] =
                        paired_push[swmm_pkg::CNT_OUT_W-1:0];
                    n_out_tdata[swmm_pkg::OUT_TOT_LSB +: TOT_W] = total_push;
                end
                default: begin
                    // Undefined opcode: the current counts are reported unchanged.
                end
            endcase
        end

        // A new window length empties the window and sweeps the window counts.
        if (i_cfg.restart) begin
            n_fill       = '0;
            n_oldest     = '0;
            n_paired     = '0;
            n_sweep      = 1'b1;
            n_sweep_ref  = r_sweep && r_sweep_ref;
            n_sweep_addr = '0;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph0        <= 1'b0;
            r_ph1        <= 1'b0;
            r_pend_valid <= 1'b0;
            r_fill       <= '0;
            r_oldest     <= '0;
            r_paired     <= '0;
            r_total      <= '0;
            r_sweep      <= 1'b1;
            r_sweep_ref  <= 1'b1;
            r_sweep_addr <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_ph0 <= take;
            if (r_ph0) begin
                r_ph1 <= 1'b1;
            end else if (fire1) begin
                r_ph1 <= 1'b0;
            end
            r_pend_valid <= fire1 && (r_op == swmm_pkg::OP_PUSH);
            r_fill       <= n_fill;
            r_oldest     <= n_oldest;
            r_paired     <= n_paired;
            r_total      <= n_total;
            r_sweep      <= n_sweep;
            r_sweep_ref  <= n_sweep_ref;
            r_sweep_addr <= n_sweep_addr;
            if (fire1) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request payload, forwarding snapshot and the prefetched oldest value.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_op  <= i_op;
            r_sym <= i_sym;
        end
        if (r_ph0) begin
            r_evict    <= evict_now;
            r_fwd_a    <= r_pend_valid && (r_pend_addr == r_old_val);
            r_fwd_b    <= r_pend_valid && (r_pend_addr == r_sym);
            r_fwd_data <= r_pend_data;
        end
        if (fire1) begin
            r_pend_addr <= r_sym;
            r_pend_data <= wc_s_new;
            r_out_tdata <= n_out_tdata;
            if (r_op == swmm_pkg::OP_PUSH) begin
                if (r_evict) begin
                    r_old_val <= (len_eff == FW'(1)) ? r_sym : ring_rd;
                end else if (r_fill == '0) begin
                    r_old_val <= r_sym;
                end
            end
        end
    end

    assign o_sweep    = r_sweep;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_tdata;

endmodule

[hdl/sliding_window_multiset_match.sv]
// Sliding-window multiset match: each request is a clear, a reference load or a
// stream push, and each one gives exactly one result. A push reports whether the
// window is full, whether the paired count of a full window reaches the threshold,
// the paired count and the saturating total of qualifying windows. While results
// are taken promptly, the engine takes a new request only once the previous one
// leaves phase one; the window count RAM's single write port takes the evicted and
// the entered count of each push in turn. A request passes the input register and
// the two engine phases before it reaches the result register. After reset and
// after a clear request both count tables are swept over all ALPHABET_SIZE entries
// (1024 by default), after a window_length write the window count table, and no
// request is accepted during a sweep; configuration writes are taken at any time
// but belong in idle periods, and a window_length write empties the window.
`include "assert_macros.svh"

module sliding_window_multiset_match #(
    parameter int ALPHABET_SIZE = swmm_pkg::ALPHABET_SIZE_DEF,
    parameter int WINDOW_MAX    = swmm_pkg::WINDOW_MAX_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Request stream.
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [9:0] value, [15:10] zero
    input  logic [swmm_pkg::S_TDATA_W-1:0] i_s_tdata,
    // [1:0] opcode
    input  logic [swmm_pkg::S_TUSER_W-1:0] i_s_tuser,
    // Result stream.
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [0] window_full, [1] match, [10:2] match_count,
    // [42:11] matching_windows, [47:43] zero
    output logic [swmm_pkg::M_TDATA_W-1:0] o_m_tdata,
    // Configuration writes.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [swmm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [swmm_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int AW = $clog2(ALPHABET_SIZE);

    logic [swmm_pkg::CFG_W-1:0] r_window_length;
    logic [swmm_pkg::CFG_W-1:0] r_threshold;
    swmm_pkg::t_cfg             cfg;
    logic                       fold_valid;
    logic [swmm_pkg::OP_W-1:0]  fold_op;
    logic [AW-1:0]              fold_sym;
    logic                       core_take;
    logic                       core_sweep;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= swmm_pkg::CFG_W'(1);
            r_threshold     <= swmm_pkg::CFG_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                swmm_pkg::CFG_WINDOW_LENGTH:   r_window_length <= i_cfg_data;
                swmm_pkg::CFG_MATCH_THRESHOLD: r_threshold     <= i_cfg_data;
                default: begin
                    // Writes beyond the register list are dropped.
                end
            endcase
        end
    end

    assign cfg.window_length = r_window_length;
    assign cfg.threshold     = r_threshold;
    assign cfg.restart       = i_cfg_valid && (i_cfg_index == swmm_pkg::CFG_WINDOW_LENGTH);

    // Input stage with symbol folding.
    swmm_fold #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_op    (i_s_tuser[swmm_pkg::OP_W-1:0]),
        .i_value (i_s_tdata[swmm_pkg::VAL_W-1:0]),
        .i_block (core_sweep),
        .o_valid (fold_valid),
        .i_take  (core_take),
        .o_op    (fold_op),
        .o_sym   (fold_sym)
    );

    // Match engine.
    swmm_core #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .WINDOW_MAX    (WINDOW_MAX)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_valid    (fold_valid),
        .i_op       (fold_op),
        .i_sym      (fold_sym),
        .o_take     (core_take),
        .o_sweep    (core_sweep),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // No request is accepted while the tables are being swept.
    `SWMM_ASSERT_IMPLIES(a_no_request_in_sweep, i_clk, i_rst_n, core_sweep, !o_s_tready)

    // A qualifying result always comes from a full window.
    `SWMM_ASSERT_IMPLIES(a_match_needs_full, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[1], o_m_tdata[0])

    // A qualifying result has already been counted in the running total.
    `SWMM_ASSERT_IMPLIES(a_match_counted, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[1], o_m_tdata[42:11] != 32'd0)

    // A window_length write starts a sweep of the window counts.
    `SWMM_ASSERT_NEXT(a_length_write_sweeps, i_clk, i_rst_n, i_cfg_valid && (i_cfg_index == swmm_pkg::CFG_WINDOW_LENGTH), core_sweep)

endmodule
